### hw/rtl/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
// Used by fpba_cfg, fpba_seq and the top level under hw/rtl; depends on nothing else.
package fpba_pkg;

    localparam int ARENA_BYTES  = 16384;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 64;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W  = 14;
    localparam int SIZE_W = 15;
    localparam int END_W  = 17;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_GAP    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic CMD_FREE = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  granted;
        logic [SIZE_W-1:0] remaining;
    } result_t;

endpackage

### hw/rtl/fpba_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered: it appears in the cycle after rd_en. No dependencies.
module fpba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 29
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/fpba_cfg.sv
// APB configuration register holding the fit policy.
// Depends on fpba_pkg.
module fpba_cfg
    import fpba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [1:0]  fit_policy
);

    logic [1:0] policy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 2'd0;
        end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
            policy_reg <= pwdata[1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr == 1'b0) ? {30'd0, policy_reg} : 32'd0;
    assign fit_policy = policy_reg;

endmodule

### hw/rtl/fpba_seq.sv
// Sequencer that scans, shifts and updates the block table in RAM.
// Depends on fpba_pkg and fpba_ram.
module fpba_seq
    import fpba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        fit_policy,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              req_command,
    input  logic [SIZE_W-1:0] req_size,
    input  logic [OFF_W-1:0]  req_addr,
    output logic              res_valid,
    input  logic              res_ack,
    output result_t           res
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_LAST = 8'b0000_0100,
        S_PLAN = 8'b0000_1000,
        S_SHRD = 8'b0001_0000,
        S_SHWR = 8'b0010_0000,
        S_INS  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic               cmd_reg, cmd_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [OFF_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SIZE_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               vld_reg, vld_next;
    logic [IDX_W-1:0]   vidx_reg, vidx_next;
    logic [END_W-1:0]   prev_end_reg, prev_end_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [END_W-1:0]   pick_gap_reg, pick_gap_next;
    logic [END_W-1:0]   pick_end_reg, pick_end_next;
    logic [SIZE_W-1:0]  pick_size_reg, pick_size_next;
    logic [IDX_W-1:0]   sh_idx_reg, sh_idx_next;
    logic [1:0]         status_reg, status_next;
    logic [OFF_W-1:0]   granted_reg, granted_next;

    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    entry_t             wr_data, rd_word, ent;

    logic               cand_v;
    logic [IDX_W-1:0]   cand_idx;
    logic [END_W-1:0]   cand_gap, cand_end, cand_lim, need, ent_off, ent_end;
    logic               take;
    logic [CNT_W-1:0]   last_idx;

    fpba_ram #(.DEPTH(MAX_BLOCKS), .WIDTH($bits(entry_t))) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // The sentinel entry is never written; it is forced to read as zero here.
    assign ent      = (vidx_reg == '0) ? '0 : rd_word;
    assign ent_off  = END_W'(ent.offset);
    assign ent_end  = ent_off + END_W'(HEADER_BYTES) + END_W'(ent.size);
    assign need     = END_W'(size_reg) + END_W'(HEADER_BYTES);
    assign last_idx = count_reg - CNT_W'(1);

    always_comb begin
        cand_v   = 1'b0;
        cand_idx = vidx_reg - IDX_W'(1);
        cand_lim = ent_off;
        if (state_reg == S_LAST) begin
            cand_v   = 1'b1;
            cand_idx = last_idx[IDX_W-1:0];
            cand_lim = END_W'(ARENA_BYTES);
        end else if (state_reg == S_SCAN && vld_reg && vidx_reg != '0) begin
            cand_v = 1'b1;
        end
        cand_end = prev_end_reg;
        cand_gap = (cand_lim > prev_end_reg) ? cand_lim - prev_end_reg : '0;
        take = cand_v && (cmd_reg != CMD_FREE) && (cand_gap >= need) &&
               (!found_reg || (fit_policy == POL_BEST && cand_gap < pick_gap_reg) ||
                (fit_policy == POL_WORST && cand_gap > pick_gap_reg));
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        rd_idx_next    = rd_idx_reg;
        vld_next       = 1'b0;
        vidx_next      = vidx_reg;
        prev_end_next  = prev_end_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_gap_next  = pick_gap_reg;
        pick_end_next  = pick_end_reg;
        pick_size_next = pick_size_reg;
        sh_idx_next    = sh_idx_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        wr_en          = 1'b0;
        wr_addr        = sh_idx_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[IDX_W-1:0];

        if (take) begin
            found_next    = 1'b1;
            pick_next     = cand_idx;
            pick_gap_next = cand_gap;
            pick_end_next = cand_end;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    cmd_next     = req_command;
                    size_next    = req_size;
                    addr_next    = req_addr;
                    rd_idx_next  = '0;
                    found_next   = 1'b0;
                    status_next  = ST_OK;
                    granted_next = '0;
                    if (req_command != CMD_FREE && count_reg == CNT_W'(MAX_BLOCKS)) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_idx_reg < count_reg) begin
                    rd_en       = 1'b1;
                    vld_next    = 1'b1;
                    vidx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (vld_reg) begin
                    prev_end_next = ent_end;
                    if (cmd_reg == CMD_FREE && vidx_reg != '0 && !found_reg &&
                        ent_off + END_W'(HEADER_BYTES) == END_W'(addr_reg)) begin
                        found_next     = 1'b1;
                        pick_next      = vidx_reg;
                        pick_size_next = ent.size;
                    end
                    if ({1'b0, vidx_reg} == last_idx) begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST: begin
                state_next = S_PLAN;
            end
            S_PLAN: begin
                if (!found_reg) begin
                    status_next = (cmd_reg == CMD_FREE) ? ST_NOT_FOUND : ST_NO_GAP;
                    state_next  = S_DONE;
                end else if (cmd_reg != CMD_FREE) begin
                    sh_idx_next = count_reg[IDX_W-1:0];
                    state_next  = (count_reg > CNT_W'(pick_reg) + CNT_W'(1)) ? S_SHRD : S_INS;
                end else begin
                    sh_idx_next = pick_reg;
                    if (CNT_W'(pick_reg) + CNT_W'(1) < count_reg) begin
                        state_next = S_SHRD;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        free_next  = free_reg + pick_size_reg + SIZE_W'(HEADER_BYTES);
                        state_next = S_DONE;
                    end
                end
            end
            S_SHRD: begin
                rd_en     = 1'b1;
                vidx_next = sh_idx_reg;
                rd_addr   = (cmd_reg != CMD_FREE) ? sh_idx_reg - IDX_W'(1)
                                                  : sh_idx_reg + IDX_W'(1);
                state_next = S_SHWR;
            end
            S_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = sh_idx_reg;
                wr_data = rd_word;
                if (cmd_reg != CMD_FREE) begin
                    sh_idx_next = sh_idx_reg - IDX_W'(1);
                    state_next  = (CNT_W'(sh_idx_reg) > CNT_W'(pick_reg) + CNT_W'(2))
                                  ? S_SHRD : S_INS;
                end else begin
                    sh_idx_next = sh_idx_reg + IDX_W'(1);
                    if (CNT_W'(sh_idx_reg) + CNT_W'(2) < count_reg) begin
                        state_next = S_SHRD;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        free_next  = free_reg + pick_size_reg + SIZE_W'(HEADER_BYTES);
                        state_next = S_DONE;
                    end
                end
            end
            S_INS: begin
                wr_en          = 1'b1;
                wr_addr        = pick_reg + IDX_W'(1);
                wr_data.offset = pick_end_reg[OFF_W-1:0];
                wr_data.size   = size_reg;
                count_next     = count_reg + CNT_W'(1);
                free_next      = free_reg - size_reg - SIZE_W'(HEADER_BYTES);
                granted_next   = OFF_W'(pick_end_reg + END_W'(HEADER_BYTES));
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (res_ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
            free_reg  <= SIZE_W'(ARENA_BYTES - HEADER_BYTES);
            vld_reg   <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            vld_reg   <= vld_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        vidx_reg      <= vidx_next;
        prev_end_reg  <= prev_end_next;
        pick_reg      <= pick_next;
        pick_gap_reg  <= pick_gap_next;
        pick_end_reg  <= pick_end_next;
        pick_size_reg <= pick_size_next;
        sh_idx_reg    <= sh_idx_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    assign req_ready     = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.granted   = granted_reg;
    assign res.remaining = free_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");

    a_sentinel_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> wr_addr != '0)
        else $error("write to sentinel entry");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> $past(state_reg == S_INS ||
            state_reg == S_SHWR || state_reg == S_PLAN))
        else $error("block count changed outside an update");

endmodule

### hw/rtl/fit_policy_block_allocator_top.sv
// Top level of the fit-policy block allocator: stream ports, APB port, result register.
// Depends on fpba_pkg, fpba_cfg and fpba_seq.
// Each request scans the block table in RAM one entry per cycle, then moves entries as needed;
// one transaction is handled at a time, and a new request is taken only in the idle state.
// Reset (aresetn, synchronous, active low) leaves only the sentinel block and first fit.
module fit_policy_block_allocator_top
    import fpba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // alloc_size[14:0], release_address[28:15]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // status[1:0], granted_address[15:2], remaining_free[30:16]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       policy;
    logic [1:0] fit_policy;
    logic       req_ready, res_valid, res_ack;
    result_t    res;
    logic       out_valid_reg;
    result_t    out_reg;

    fpba_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fit_policy (fit_policy)
    );

    fpba_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fit_policy  (fit_policy),
        .req_valid   (s_axis_tvalid),
        .req_ready   (req_ready),
        .req_command (s_axis_tuser),
        .req_size    (s_axis_tdata[14:0]),
        .req_addr    (s_axis_tdata[28:15]),
        .res_valid   (res_valid),
        .res_ack     (res_ack),
        .res         (res)
    );

    assign policy  = !out_valid_reg || m_axis_tready;
    assign res_ack = res_valid && policy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (policy) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            out_reg <= res;
        end
    end

    assign s_axis_tready = req_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.remaining, out_reg.granted, out_reg.status};

endmodule
